// ----- hw/rtl/chsd_pkg.sv -----
// Package for the canonical Huffman symbol decoder: table sizes, widths,
// operation and status codes and the walker status structure.
// Depends on nothing; the code walker and the top level use it.
`default_nettype none

package chsd_pkg;

   localparam int MAX_CODE_LENGTH = 16;
   localparam int SYMBOL_DEPTH    = 256;

   localparam int WIN_W    = 24;
   localparam int OFF_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int ADV_W    = 2;
   localparam int USED_W   = 5;

   localparam int LEN_W  = (MAX_CODE_LENGTH > 2) ? $clog2(MAX_CODE_LENGTH) : 1;
   localparam int CODE_W = (MAX_CODE_LENGTH + 1 > 9) ? MAX_CODE_LENGTH + 1 : 9;
   localparam int SUM_W  = $clog2(MAX_CODE_LENGTH * 255 + 1);
   localparam int SYM_AW = $clog2(SYMBOL_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_COUNT  = 2'd0,
      OP_LOAD_SYMBOL = 2'd1,
      OP_DECODE      = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_CODE  = 2'd1,
      ST_BAD_TABLE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic              done;
      logic              table_ok;
      logic              found;
      logic [SYM_AW-1:0] sym_addr;
      logic [USED_W-1:0] used;
      logic [OFF_W-1:0]  offset;
   } walk_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/chsd_symbol_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the symbol list of the decoder; depends on nothing.
`default_nettype none

module chsd_symbol_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/chsd_code_walker.sv -----
// Length count registers and the sequencer that walks the code lengths one per
// cycle, checking the table and locating the matching canonical code.
// Depends on chsd_pkg.
`default_nettype none

module chsd_code_walker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           count_we,
   input  wire logic [chsd_pkg::BYTE_W-1:0]    count_index,
   input  wire logic [chsd_pkg::BYTE_W-1:0]    count_value,
   input  wire logic                           start,
   input  wire logic [chsd_pkg::WIN_W-1:0]     bit_window,
   input  wire logic [chsd_pkg::OFF_W-1:0]     bit_offset,
   output chsd_pkg::walk_status_type           walk_status
);

   logic [chsd_pkg::BYTE_W-1:0] count_ff [chsd_pkg::MAX_CODE_LENGTH];

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [chsd_pkg::LEN_W-1:0]    step_ff, step_in;
   logic [chsd_pkg::WIN_W-1:0]    win_ff, win_in;
   logic [chsd_pkg::CODE_W-1:0]   v_ff, v_in;
   logic [chsd_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [chsd_pkg::CODE_W-1:0]   free_ff, free_in;
   logic [chsd_pkg::SUM_W-1:0]    base_ff, base_in;
   logic [chsd_pkg::SUM_W-1:0]    idx_ff, idx_in;
   logic [chsd_pkg::USED_W-1:0]   used_ff, used_in;
   logic [chsd_pkg::OFF_W-1:0]    off_ff, off_in;
   logic                          bad_ff, bad_in;
   logic                          found_ff, found_in;

   logic [chsd_pkg::CODE_W-1:0]   cnt;
   logic [chsd_pkg::CODE_W-1:0]   diff;
   logic                          hit;
   logic                          last;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < chsd_pkg::MAX_CODE_LENGTH; i++) begin
            count_ff[i] <= '0;
         end
      end else if (count_we &&
                   count_index < chsd_pkg::BYTE_W'(chsd_pkg::MAX_CODE_LENGTH)) begin
         count_ff[count_index[chsd_pkg::LEN_W-1:0]] <= count_value;
      end
   end

   always_comb begin
      cnt  = chsd_pkg::CODE_W'(count_ff[step_ff]);
      last = (step_ff == chsd_pkg::LEN_W'(chsd_pkg::MAX_CODE_LENGTH - 1));
      v_in = {v_ff[chsd_pkg::CODE_W-2:0], win_ff[chsd_pkg::WIN_W-1]};
      diff = v_in - code_ff;
      hit  = (v_in >= code_ff) && (diff < cnt);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      win_in   = win_ff;
      code_in  = code_ff;
      free_in  = free_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      used_in  = used_ff;
      off_in   = off_ff;
      bad_in   = bad_ff;
      found_in = found_ff;

      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         win_in   = bit_window << bit_offset;
         v_in     = '0;
         code_in  = '0;
         free_in  = chsd_pkg::CODE_W'(2);
         base_in  = '0;
         off_in   = bit_offset;
         bad_in   = 1'b0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         win_in  = win_ff << 1;
         code_in = (code_ff + cnt) << 1;
         free_in = (free_ff - cnt) << 1;
         base_in = base_ff + chsd_pkg::SUM_W'(cnt);
         step_in = step_ff + chsd_pkg::LEN_W'(1);
         if (cnt > free_ff) begin
            bad_in = 1'b1;
         end
         if (hit && !found_ff) begin
            found_in = 1'b1;
            idx_in   = base_ff + chsd_pkg::SUM_W'(diff[chsd_pkg::BYTE_W-1:0]);
            used_in  = chsd_pkg::USED_W'(off_ff) + chsd_pkg::USED_W'(step_ff) +
                       chsd_pkg::USED_W'(1);
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         v_in = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      win_ff   <= win_in;
      v_ff     <= v_in;
      code_ff  <= code_in;
      free_ff  <= free_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      used_ff  <= used_in;
      off_ff   <= off_in;
      bad_ff   <= bad_in;
      found_ff <= found_in;
   end

   always_comb begin
      walk_status.done     = done_ff;
      walk_status.table_ok = !bad_ff &&
                             (base_ff <= chsd_pkg::SUM_W'(chsd_pkg::SYMBOL_DEPTH));
      walk_status.found    = found_ff;
      walk_status.sym_addr = idx_ff[chsd_pkg::SYM_AW-1:0];
      walk_status.used     = used_ff;
      walk_status.offset   = off_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/canonical_huffman_symbol_decoder.sv -----
// Top level of the canonical Huffman symbol decoder: handshakes, sequencing,
// symbol memory and the result register. Depends on chsd_pkg,
// chsd_symbol_ram and chsd_code_walker.
//
// A load word (count or symbol entry) is taken while the block is idle and
// gives no result. A decode word walks the code lengths one per cycle in the
// code walker, then reads the symbol memory once; the block stalls further
// words until the result is loaded into the result register, which waits on
// rsp_stall while that register is full. The result register lets the next
// word in while a result is still pending. Length counts reset to zero;
// symbol entries are undefined until loaded.
`default_nettype none

module canonical_huffman_symbol_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [chsd_pkg::OP_W-1:0]         req_operation,
   input  wire logic [chsd_pkg::BYTE_W-1:0]       req_table_index,
   input  wire logic [chsd_pkg::BYTE_W-1:0]       req_table_value,
   input  wire logic [chsd_pkg::WIN_W-1:0]        req_bit_window,
   input  wire logic [chsd_pkg::OFF_W-1:0]        req_bit_offset,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [chsd_pkg::BYTE_W-1:0]       rsp_symbol,
   output logic      [chsd_pkg::ADV_W-1:0]        rsp_bytes_advanced,
   output logic      [chsd_pkg::OFF_W-1:0]        rsp_next_bit_offset,
   output logic      [chsd_pkg::STATUS_W-1:0]     rsp_status
);

   chsd_pkg::state_type        state_ff, state_in;
   chsd_pkg::walk_status_type  walk_status;

   logic                              accept;
   logic                              start;
   logic                              count_we;
   logic                              sym_we;
   logic [chsd_pkg::BYTE_W-1:0]       rd_data;
   logic                              rsp_load;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [chsd_pkg::BYTE_W-1:0]       rsp_symbol_ff, rsp_symbol_in;
   logic [chsd_pkg::ADV_W-1:0]        rsp_adv_ff, rsp_adv_in;
   logic [chsd_pkg::OFF_W-1:0]        rsp_off_ff, rsp_off_in;
   logic [chsd_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   assign req_stall = (state_ff != chsd_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign count_we  = accept && (req_operation == chsd_pkg::OP_LOAD_COUNT);
   assign sym_we    = accept && (req_operation == chsd_pkg::OP_LOAD_SYMBOL) &&
                      ({1'b0, req_table_index} <
                       (chsd_pkg::BYTE_W + 1)'(chsd_pkg::SYMBOL_DEPTH));
   assign rsp_load  = (state_ff == chsd_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   chsd_code_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .count_we    (count_we),
      .count_index (req_table_index),
      .count_value (req_table_value),
      .start       (start),
      .bit_window  (req_bit_window),
      .bit_offset  (req_bit_offset),
      .walk_status (walk_status)
   );

   chsd_symbol_ram #(
      .DEPTH (chsd_pkg::SYMBOL_DEPTH),
      .WIDTH (chsd_pkg::BYTE_W)
   ) u_symbols (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (req_table_index[chsd_pkg::SYM_AW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (walk_status.done),
      .rd_addr (walk_status.sym_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      unique case (state_ff)
         chsd_pkg::S_IDLE: begin
            if (accept && (req_operation == chsd_pkg::OP_DECODE)) begin
               start    = 1'b1;
               state_in = chsd_pkg::S_WALK;
            end
         end
         chsd_pkg::S_WALK: begin
            if (walk_status.done) begin
               state_in = chsd_pkg::S_DONE;
            end
         end
         chsd_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = chsd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chsd_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_symbol_in = '0;
      rsp_adv_in    = '0;
      rsp_off_in    = walk_status.offset;
      priority if (!walk_status.table_ok) begin
         rsp_status_in = chsd_pkg::ST_BAD_TABLE;
      end else if (!walk_status.found) begin
         rsp_status_in = chsd_pkg::ST_BAD_CODE;
      end else begin
         rsp_status_in = chsd_pkg::ST_OK;
         rsp_symbol_in = rd_data;
         rsp_adv_in    = walk_status.used[chsd_pkg::USED_W-1:chsd_pkg::OFF_W];
         rsp_off_in    = walk_status.used[chsd_pkg::OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chsd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_symbol_ff <= rsp_symbol_in;
         rsp_adv_ff    <= rsp_adv_in;
         rsp_off_ff    <= rsp_off_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_symbol          = rsp_symbol_ff;
   assign rsp_bytes_advanced  = rsp_adv_ff;
   assign rsp_next_bit_offset = rsp_off_ff;
   assign rsp_status          = rsp_status_ff;

   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_status.done |-> (state_ff == chsd_pkg::S_WALK))
      else $error("Walker finished outside the walk state.");

   a_decode_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == chsd_pkg::OP_DECODE)) |=> (state_ff == chsd_pkg::S_WALK))
      else $error("Accepted decode word did not start a walk.");

   a_error_consumes_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != chsd_pkg::ST_OK)) |->
      ((rsp_symbol == '0) && (rsp_bytes_advanced == '0)))
      else $error("Failed decode reports consumed bits or a symbol.");

   a_advance_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bytes_advanced != 2'd3))
      else $error("Advance beyond the three-byte window.");

endmodule

`default_nettype wire
